### rtl/column_edge_scan_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for column_edge_scan
// Shorthand for the concurrent checks that run on the top level's ports.
// ----------------------------------------------------------------------------
`ifndef COLUMN_EDGE_SCAN_MACROS_SVH
`define COLUMN_EDGE_SCAN_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CES_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CES_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/ces_pkg.sv
// ----------------------------------------------------------------------------
// ces_pkg
// Constants, types and helper functions shared by the column edge scanner.
// ----------------------------------------------------------------------------
package ces_pkg;

  localparam int MAX_ROWS = 1024;
  localparam int MAX_COLS = 1024;

  localparam int ROW_W   = $clog2(MAX_ROWS);
  localparam int COL_W   = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int FIELD_W = 10;
  localparam int PIX_W   = 8;
  localparam int MODE_W  = 2;
  localparam int CFG_IDX_W = 2;

  localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(MAX_ROWS - 1);
  localparam logic [COL_W-1:0] COL_LAST = COL_W'(MAX_COLS - 1);

  localparam logic [PIX_W-1:0]  THRESHOLD_RESET = 8'd200;
  localparam logic [MODE_W-1:0] MODE_RESET      = 2'd0;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_THRESHOLD = 2'd0,
    CFG_MODE      = 2'd1
  } cfg_index_e;

  typedef enum logic [MODE_W-1:0] {
    MODE_ANY     = 2'd0,
    MODE_INNER   = 2'd1,
    MODE_ORDERED = 2'd2
  } accept_mode_e;

  typedef struct packed {
    logic [PIX_W-1:0]  threshold;
    logic [MODE_W-1:0] mode;
  } ces_cfg_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             column_end;
    logic             frame_end;
  } ces_item_t;

  function automatic logic [FIELD_W-1:0] row_field(input logic [ROW_W-1:0] row);
    logic [ROW_W+FIELD_W-1:0] ext;
    ext = {{FIELD_W{1'b0}}, row};
    return ext[FIELD_W-1:0];
  endfunction

  function automatic logic [FIELD_W-1:0] col_field(input logic [COL_W-1:0] col);
    logic [COL_W+FIELD_W-1:0] ext;
    ext = {{FIELD_W{1'b0}}, col};
    return ext[FIELD_W-1:0];
  endfunction

endpackage

### rtl/ces_cfg_regs.sv
// ----------------------------------------------------------------------------
// ces_cfg_regs
// Holds the hit threshold and the accept mode written over the config port.
// ----------------------------------------------------------------------------
module ces_cfg_regs import ces_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [PIX_W-1:0]     cfg_data_i,
  output ces_cfg_t             cfg_o
);

  ces_cfg_t cfg_d, cfg_q;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_THRESHOLD: cfg_d.threshold = cfg_data_i;
        CFG_MODE:      cfg_d.mode      = cfg_data_i[MODE_W-1:0];
        default:       cfg_d           = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.threshold <= THRESHOLD_RESET;
      cfg_q.mode      <= MODE_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

### rtl/ces_in_stage.sv
// ----------------------------------------------------------------------------
// ces_in_stage
// Input register that captures one pixel request and holds it for the scan.
// ----------------------------------------------------------------------------
module ces_in_stage import ces_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [PIX_W-1:0] pixel_i,
  input  logic             column_end_i,
  input  logic             frame_end_i,
  input  logic             advance_i,
  output logic             valid_o,
  output ces_item_t        item_o
);

  logic      valid_d, valid_q;
  ces_item_t item_q;
  logic      load;

  assign in_ready_o = !valid_q || advance_i;
  assign load       = in_valid_i && in_ready_o;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q.pixel      <= pixel_i;
      item_q.column_end <= column_end_i;
      item_q.frame_end  <= frame_end_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

### rtl/ces_scan.sv
// ----------------------------------------------------------------------------
// ces_scan
// Per-column hit tracking, column evaluation and the result register.
// ----------------------------------------------------------------------------
module ces_scan import ces_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ces_cfg_t           cfg_i,
  input  logic               valid_i,
  input  ces_item_t          item_i,
  output logic               advance_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [FIELD_W-1:0] column_index_o,
  output logic [FIELD_W-1:0] top_row_o,
  output logic [FIELD_W-1:0] bottom_row_o
);

  logic [ROW_W-1:0]   row_d, row_q;
  logic [COL_W-1:0]   col_d, col_q;
  logic [ROW_W-1:0]   first_d, first_q;
  logic [ROW_W-1:0]   last_d, last_q;
  logic               seen_d, seen_q;
  logic               out_valid_d, out_valid_q;
  logic [FIELD_W-1:0] col_out_q, top_out_q, bot_out_q;

  logic             hit;
  logic             col_done;
  logic             accepted;
  logic             emit;
  logic [ROW_W-1:0] first_new;
  logic [ROW_W-1:0] last_new;
  logic             seen_new;

  assign advance_o = valid_i && (!out_valid_q || out_ready_i);

  assign hit       = item_i.pixel > cfg_i.threshold;
  assign col_done  = item_i.column_end || item_i.frame_end;
  assign first_new = (hit && !seen_q) ? row_q : first_q;
  assign last_new  = hit ? row_q : last_q;
  assign seen_new  = seen_q || hit;

  always_comb begin
    case (cfg_i.mode)
      MODE_ANY:     accepted = seen_new;
      MODE_INNER:   accepted = seen_new && (first_new != '0) && (last_new != '0);
      MODE_ORDERED: accepted = seen_new && (last_new > first_new);
      default:      accepted = 1'b0;
    endcase
  end

  assign emit = advance_o && col_done && accepted;

  always_comb begin
    row_d   = row_q;
    col_d   = col_q;
    first_d = first_q;
    last_d  = last_q;
    seen_d  = seen_q;
    if (advance_o) begin
      if (col_done) begin
        row_d   = '0;
        first_d = '0;
        last_d  = '0;
        seen_d  = 1'b0;
        if (item_i.frame_end) begin
          col_d = '0;
        end else if (col_q < COL_LAST) begin
          col_d = col_q + 1'b1;
        end
      end else begin
        first_d = first_new;
        last_d  = last_new;
        seen_d  = seen_new;
        if (row_q < ROW_LAST) begin
          row_d = row_q + 1'b1;
        end
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q       <= '0;
      col_q       <= '0;
      first_q     <= '0;
      last_q      <= '0;
      seen_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      row_q       <= row_d;
      col_q       <= col_d;
      first_q     <= first_d;
      last_q      <= last_d;
      seen_q      <= seen_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      col_out_q <= col_field(col_q);
      top_out_q <= row_field(first_new);
      bot_out_q <= row_field(last_new);
    end
  end

  assign out_valid_o    = out_valid_q;
  assign column_index_o = col_out_q;
  assign top_row_o      = top_out_q;
  assign bottom_row_o   = bot_out_q;

endmodule

### rtl/column_edge_scan.sv
// ----------------------------------------------------------------------------
// column_edge_scan
// Finds the top and bottom bright rows of each column of a column-major image.
// ----------------------------------------------------------------------------
//  channel  direction  handshake              payload
//  in       sink       in_valid/in_ready      pixel, column_end, frame_end
//  out      source     out_valid/out_ready    column_index, top_row, bottom_row
//  cfg      sink       cfg_valid/cfg_ready    cfg_index, cfg_data
//
// One pixel request is accepted per cycle unless a stalled result holds it up;
// results leave through the input register and then the result register.
// Reset returns the threshold to 200, the mode to 0 and clears all counters.
// A stalled result holds in the result register while one more pixel waits in
// the input register; the config port is always ready.
module column_edge_scan import ces_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [PIX_W-1:0]     pixel_i,
  input  logic                 column_end_i,
  input  logic                 frame_end_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [FIELD_W-1:0]   column_index_o,
  output logic [FIELD_W-1:0]   top_row_o,
  output logic [FIELD_W-1:0]   bottom_row_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [PIX_W-1:0]     cfg_data_i
);

  ces_cfg_t  cfg;
  ces_item_t item;
  logic      stage_valid;
  logic      stage_advance;

  ces_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  ces_in_stage u_in (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .pixel_i      (pixel_i),
    .column_end_i (column_end_i),
    .frame_end_i  (frame_end_i),
    .advance_i    (stage_advance),
    .valid_o      (stage_valid),
    .item_o       (item)
  );

  ces_scan u_scan (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg),
    .valid_i        (stage_valid),
    .item_i         (item),
    .advance_o      (stage_advance),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .column_index_o (column_index_o),
    .top_row_o      (top_row_o),
    .bottom_row_o   (bottom_row_o)
  );

endmodule

### rtl/ces_checker.sv
// ----------------------------------------------------------------------------
// ces_checker
// Port-level checks for column_edge_scan, bound to the top level.
// ----------------------------------------------------------------------------
`include "column_edge_scan_macros.svh"

module ces_checker import ces_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic [FIELD_W-1:0] column_index_o,
  input logic [FIELD_W-1:0] top_row_o,
  input logic [FIELD_W-1:0] bottom_row_o,
  input logic               cfg_ready_o
);

  `CES_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o && $stable(column_index_o) && $stable(top_row_o) && $stable(bottom_row_o), "Stalled result changed")
  `CES_ASSERT_SAME(a_row_order, clk_i, rst_ni, out_valid_o, top_row_o <= bottom_row_o, "Top row below bottom row")
  `CES_ASSERT_SAME(a_rose_src, clk_i, rst_ni, $rose(out_valid_o), $past(in_valid_i && in_ready_o, 2), "Result without a pixel two cycles earlier")
  `CES_ASSERT_SAME(a_in_free, clk_i, rst_ni, !out_valid_o && $past(!out_valid_o), in_ready_o, "Input stalled with an empty result register")
  `CES_ASSERT_SAME(a_cfg_ready, clk_i, rst_ni, 1'b1, cfg_ready_o, "Config port not ready")

endmodule

bind column_edge_scan ces_checker u_ces_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_ready_o     (in_ready_o),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .column_index_o (column_index_o),
  .top_row_o      (top_row_o),
  .bottom_row_o   (bottom_row_o),
  .cfg_ready_o    (cfg_ready_o)
);
